@@ hdl/cht_pkg.sv @@
// Package for the chained hash table: sizes, payload types, control structs and states.
package cht_pkg;

  localparam int BUCKETS  = 256;
  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 31;
  localparam int IDX_W    = 10;
  localparam int BKT_W    = $clog2(BUCKETS);
  localparam int NODE_AW  = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic {
    FN_LOOKUP = 1'b0,
    FN_INSERT = 1'b1
  } cht_func_t;

  typedef struct packed {
    cht_func_t        func;
    logic [KEY_W-1:0] key;
  } cht_in_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] node_index;
    logic             pool_full;
  } cht_out_t;

  typedef struct packed {
    logic               we;
    logic [NODE_AW-1:0] waddr;
    logic [KEY_W-1:0]   wkey;
    logic [NODE_AW-1:0] wnext;
    logic [NODE_AW-1:0] raddr;
  } cht_node_req_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [NODE_AW-1:0] next;
  } cht_node_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_NODE,
    ST_DONE
  } cht_state_t;

endpackage

@@ hdl/cht_node_mem.sv @@
// Node pool storage: key and next link per node, one write port and one registered read port.
module cht_node_mem (
  input  logic                   clk,
  input  cht_pkg::cht_node_req_t req,
  output cht_pkg::cht_node_rsp_t rsp
);
  import cht_pkg::*;

  logic [KEY_W-1:0]   key_mem  [CAPACITY];
  logic [NODE_AW-1:0] next_mem [CAPACITY];
  cht_node_rsp_t      rsp_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      key_mem[req.waddr]  <= req.wkey;
      next_mem[req.waddr] <= req.wnext;
    end
    rsp_r.key  <= key_mem[req.raddr];
    rsp_r.next <= next_mem[req.raddr];
  end

  assign rsp = rsp_r;

endmodule

@@ hdl/chained_hash_table_unit.sv @@
// Top level of the chained hash table: bucket heads, chain-walk sequencer and result register.
// A hash table of 31-bit keys with separate chaining over a pool of 1024 nodes and 256 buckets;
// a key's bucket is its low 8 bits. One item is worked at a time. An insert passes through the
// idle, head read and done states before the next item is accepted. A lookup passes through
// idle, head read, one node step per chain node visited (none for an empty bucket) and done,
// because the walk reads one node per cycle through the single read port of the node pool and
// checks it with one key comparator. A finished result moves to the output register, and the
// next item is accepted while it waits there. If the previous result is still stalled in that
// register, the sequencer holds in its done state until the register frees.
// A lookup returns the newest matching node. An insert into a full pool is refused with
// pool_full set and changes nothing. Bucket heads carry valid bits cleared by reset, so no
// clearing pass is needed after reset.
module chained_hash_table_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cht_pkg::cht_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cht_pkg::cht_out_t out_data
);
  import cht_pkg::*;

  cht_state_t         state_r, state_nxt;
  cht_func_t          func_r;
  logic [KEY_W-1:0]   key_r;
  logic [BKT_W-1:0]   bkt_r;
  logic [NODE_AW-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0]   used_r;

  logic [NODE_AW-1:0] head_mem [BUCKETS];
  logic [BUCKETS-1:0] head_vld_r;
  logic [NODE_AW-1:0] head_q_r;
  logic               head_v_r;
  logic               head_we;

  cht_out_t           res_r, res_nxt;
  logic               res_ld;
  cht_out_t           out_data_r;
  logic               out_valid_r;

  cht_node_req_t      node_req;
  cht_node_rsp_t      node_rsp;

  logic               accept;
  logic               out_free;
  logic [NODE_AW-1:0] head_val;
  logic               pool_is_full;
  logic               key_hit;
  logic               head_end;
  logic               node_end;

  cht_node_mem u_node_mem (
    .clk (clk),
    .req (node_req),
    .rsp (node_rsp)
  );

  assign accept       = in_valid && (state_r == ST_IDLE);
  assign in_stall     = (state_r != ST_IDLE);
  assign out_free     = !out_valid_r || !out_stall;
  assign head_val     = head_v_r ? head_q_r : '0;
  assign pool_is_full = (used_r >= CNT_W'(CAPACITY));
  assign key_hit      = (node_rsp.key == key_r);
  assign head_end     = (func_r == FN_INSERT) || (head_val == '0);
  assign node_end     = key_hit || (node_rsp.next == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_HEAD;
      end
      ST_HEAD: begin
        state_nxt = head_end ? ST_DONE : ST_NODE;
      end
      ST_NODE: begin
        if (node_end) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    node_req.we    = 1'b0;
    node_req.waddr = used_r[NODE_AW-1:0];
    node_req.wkey  = key_r;
    node_req.wnext = head_val;
    node_req.raddr = head_val;
    head_we        = 1'b0;
    res_ld         = 1'b0;
    res_nxt        = '0;
    cur_nxt        = cur_r;
    unique case (state_r)
      ST_HEAD: begin
        if (func_r == FN_INSERT) begin
          res_ld = 1'b1;
          if (pool_is_full) begin
            res_nxt.pool_full = 1'b1;
          end else begin
            node_req.we        = 1'b1;
            head_we            = 1'b1;
            res_nxt.found      = 1'b1;
            res_nxt.node_index = IDX_W'(used_r[NODE_AW-1:0]);
          end
        end else if (head_val == '0) begin
          res_ld = 1'b1;
        end else begin
          cur_nxt = head_val;
        end
      end
      ST_NODE: begin
        node_req.raddr = node_rsp.next;
        if (key_hit) begin
          res_ld             = 1'b1;
          res_nxt.found      = 1'b1;
          res_nxt.node_index = IDX_W'(cur_r);
        end else if (node_rsp.next == '0) begin
          res_ld = 1'b1;
        end else begin
          cur_nxt = node_rsp.next;
        end
      end
      ST_IDLE, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= CNT_W'(1);
      head_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (node_req.we) used_r <= used_r + CNT_W'(1);
      if (head_we) head_vld_r[bkt_r] <= 1'b1;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_data.func;
      key_r  <= in_data.key;
      bkt_r  <= in_data.key[BKT_W-1:0];
    end
    head_q_r <= head_mem[in_data.key[BKT_W-1:0]];
    head_v_r <= head_vld_r[in_data.key[BKT_W-1:0]];
    if (head_we) head_mem[bkt_r] <= used_r[NODE_AW-1:0];
    cur_r <= cur_nxt;
    if (res_ld) res_r <= res_nxt;
    if (state_r == ST_DONE && out_free) out_data_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != '0) && (used_r <= CNT_W'(CAPACITY)))
    else $error("node count out of range");

  a_walk_no_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NODE) |-> (cur_r != '0))
    else $error("chain walk on sentinel node");

  a_insert_advances: assert property (@(posedge clk) disable iff (!rst_n)
    node_req.we |=> (used_r == $past(used_r) + CNT_W'(1)))
    else $error("insert did not take one pool node");
`endif

endmodule

@@ dv/chained_hash_table_unit_checker.sv @@
// Checker for the chained hash table unit: predicts every reply and compares it field by field.
`timescale 1ns / 1ps
module chained_hash_table_unit_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  cht_pkg::cht_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  cht_pkg::cht_out_t out_data,
  output int                replies_owed,
  output int                fault_count
);
  import cht_pkg::*;

  logic [IDX_W-1:0] head_of [BUCKETS];
  logic [KEY_W-1:0] key_of  [CAPACITY];
  logic [IDX_W-1:0] link_of [CAPACITY];
  int               pool_taken;
  cht_out_t         replies_due[$];

  function automatic cht_out_t table_access(input cht_in_t item);
    cht_out_t         reply;
    int               bucket;
    logic [IDX_W-1:0] cursor;
    int               hops;
    reply  = '0;
    bucket = item.key % BUCKETS;
    if (item.func == FN_LOOKUP) begin
      cursor = head_of[bucket];
      hops   = 0;
      while (cursor != '0 && hops < CAPACITY && !reply.found) begin
        if (key_of[cursor] == item.key) begin
          reply.found      = 1'b1;
          reply.node_index = cursor;
        end else begin
          cursor = link_of[cursor];
          hops++;
        end
      end
    end else if (pool_taken >= CAPACITY) begin
      reply.pool_full = 1'b1;
    end else begin
      key_of[pool_taken]  = item.key;
      link_of[pool_taken] = head_of[bucket];
      head_of[bucket]     = IDX_W'(pool_taken);
      reply.found         = 1'b1;
      reply.node_index    = IDX_W'(pool_taken);
      pool_taken++;
    end
    return reply;
  endfunction

  task automatic log_fault(input string what, input cht_out_t want);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%0t: %s: expected found=%0b node_index=%0d pool_full=%0b",
               $time, what, want.found, want.node_index, want.pool_full);
      $display("%0t: %s: actual   found=%0b node_index=%0d pool_full=%0b",
               $time, what, out_data.found, out_data.node_index, out_data.pool_full);
    end
  endtask

  always @(posedge clk) begin : watch
    cht_out_t want;
    if (!rst_n) begin
      foreach (head_of[b]) head_of[b] = '0;
      pool_taken  = 1;
      fault_count = 0;
      replies_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          log_fault("reply with none due", '0);
        end else begin
          want = replies_due.pop_front();
          if (out_data.found !== want.found || out_data.node_index !== want.node_index ||
              out_data.pool_full !== want.pool_full) begin
            log_fault("reply mismatch", want);
          end
        end
      end
      if (in_valid && !in_stall) replies_due.push_back(table_access(in_data));
    end
    replies_owed <= replies_due.size();
  end

endmodule

@@ dv/chained_hash_table_unit_tb.sv @@
// Testbench top for the chained hash table unit: reset, clock, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module chained_hash_table_unit_tb;
  import cht_pkg::*;

  localparam int RANDOM_ITEMS  = 1632;
  localparam int HOT_BUCKET    = 'hA5;
  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 40;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  cht_in_t  in_data   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  cht_out_t out_data;

  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int quiet_cycles      = 0;
  int replies_owed;
  int fault_count;
  logic [KEY_W-1:0] stored_keys[$];

  always #6 clk = ~clk;

  chained_hash_table_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  chained_hash_table_unit_checker reply_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .replies_owed (replies_owed),
    .fault_count  (fault_count)
  );

  always @(posedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input cht_func_t op, input logic [KEY_W-1:0] k);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{func: op, key: k};
    if (op == FN_INSERT) stored_keys.push_back(k);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
  endtask

  initial begin
    logic [KEY_W-1:0] k;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    sender_idle_pct   = 9;
    receiver_idle_pct = 85;

    send_item(FN_LOOKUP, '0);
    send_item(FN_LOOKUP, '1);
    send_item(FN_INSERT, '0);
    send_item(FN_INSERT, '1);
    send_item(FN_LOOKUP, '0);
    send_item(FN_LOOKUP, '1);
    send_item(FN_INSERT, 31'h100);
    send_item(FN_INSERT, 31'h4000_0000);
    send_item(FN_LOOKUP, '0);
    send_item(FN_LOOKUP, 31'h300);
    send_item(FN_INSERT, '0);
    send_item(FN_LOOKUP, '0);
    send_item(FN_INSERT, 31'h5555_5555);
    send_item(FN_INSERT, 31'h2AAA_AAAA);
    send_item(FN_LOOKUP, 31'h5555_5555);
    send_item(FN_LOOKUP, 31'h2AAA_AAAA);
    send_item(FN_LOOKUP, 31'h2AAA_AAAB);
    send_item(FN_LOOKUP, 31'h3FFF_FFFF);
    drain_replies();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        drain_replies();
        sender_idle_pct   = 85;
        receiver_idle_pct = 9;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        drain_replies();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      k = KEY_W'($urandom());
      if ($urandom_range(0, 3) == 0) k[BKT_W-1:0] = BKT_W'(HOT_BUCKET);
      if ($urandom_range(0, 9) < 7) begin
        if (stored_keys.size() != 0 && $urandom_range(0, 9) == 0)
          k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        send_item(FN_INSERT, k);
      end else begin
        if (stored_keys.size() != 0 && $urandom_range(0, 9) < 6)
          k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        send_item(FN_LOOKUP, k);
      end
    end

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/cht_pkg.sv
hdl/cht_node_mem.sv
hdl/chained_hash_table_unit.sv
dv/chained_hash_table_unit_checker.sv
dv/chained_hash_table_unit_tb.sv
